[rtl/frdb_pkg.sv]
package frdb_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int SQUARE_W  = 32;
  localparam int SUM_W     = 41;
  localparam int DB_W      = 7;
  localparam int FRAC_SH   = 24;
  localparam int COEF_W    = 28;
  localparam int NUM_FRAC  = 10;
  localparam int FRAC_IDX_W = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [DB_W-1:0] TOP_DB      = 7'd120;
  localparam logic [DB_W-1:0] FLOOR_RESET = 7'd20;
  localparam logic [DB_W-1:0] CEIL_RESET  = 7'd120;
  localparam logic [FRAC_IDX_W-1:0] LAST_FRAC = 4'd9;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_FLOOR = 1'b0,
    REG_CEIL  = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    LV_IDLE   = 4'b0001,
    LV_LOAD   = 4'b0010,
    LV_SEARCH = 4'b0100,
    LV_DONE   = 4'b1000
  } lvl_state_t;

  // 10^(r/10) * 2^24, rounded; the r = 0 entry is pre-scaled by ten since
  // the 0 dB step is never tested and its first use is at 10 dB
  function automatic logic [COEF_W-1:0] load_coef(input logic [FRAC_IDX_W-1:0] r);
    logic [COEF_W-1:0] c;
    case (r)
      4'd0:    c = 28'd167772160;
      4'd1:    c = 28'd21121264;
      4'd2:    c = 28'd26590095;
      4'd3:    c = 28'd33474947;
      4'd4:    c = 28'd42142461;
      4'd5:    c = 28'd53054215;
      4'd6:    c = 28'd66791300;
      4'd7:    c = 28'd84085265;
      4'd8:    c = 28'd105857077;
      4'd9:    c = 28'd133266164;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

[rtl/frdb_acc.sv]
module frdb_acc #(
  parameter int MAX_FRAME = 1024,
  parameter int CNT_W     = 11
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             take,
  input  logic signed [frdb_pkg::SAMPLE_W-1:0] sample,
  input  logic                             last_sample,
  output logic                             q_push,
  output logic [frdb_pkg::SUM_W-1:0]       q_sum,
  output logic [CNT_W-1:0]                 q_cnt
);

  logic [frdb_pkg::SUM_W-1:0]    sum_r, sum_nxt, sum_upd;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt, cnt_upd;
  logic [frdb_pkg::SAMPLE_W-1:0] mag;
  logic [frdb_pkg::SQUARE_W-1:0] square;
  logic [frdb_pkg::SUM_W:0]      sum_wide;
  logic                          room;

  assign mag      = sample[frdb_pkg::SAMPLE_W-1] ? frdb_pkg::SAMPLE_W'(-sample)
                                                 : frdb_pkg::SAMPLE_W'(sample);
  assign square   = mag * mag;
  assign sum_wide = {1'b0, sum_r} + (frdb_pkg::SUM_W+1)'(square);
  assign room     = cnt_r < CNT_W'(MAX_FRAME);

  always_comb begin
    sum_upd = sum_r;
    cnt_upd = cnt_r;
    if (room) begin
      // saturate rather than wrap on very long frames
      sum_upd = sum_wide[frdb_pkg::SUM_W] ? frdb_pkg::SUM_MAX
                                           : sum_wide[frdb_pkg::SUM_W-1:0];
      cnt_upd = cnt_r + CNT_W'(1);
    end
  end

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (take) begin
      if (last_sample) begin
        sum_nxt = '0;
        cnt_nxt = '0;
      end else begin
        sum_nxt = sum_upd;
        cnt_nxt = cnt_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign q_push = take && last_sample;
  assign q_sum  = sum_upd;
  assign q_cnt  = cnt_upd;

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CNT_W'(MAX_FRAME))
    else $error("sample count beyond frame limit");
  assert property (@(posedge clk) disable iff (!rst_n) q_push |=> cnt_r == '0 && sum_r == '0)
    else $error("accumulators not cleared after frame end");

endmodule

[rtl/frdb_queue.sv]
module frdb_queue #(
  parameter int DW = 52
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          empty
);

  localparam int PTR_W   = $clog2(frdb_pkg::QUEUE_DEPTH);
  localparam int COUNT_W = $clog2(frdb_pkg::QUEUE_DEPTH + 1);

  logic [DW-1:0]      mem_r [frdb_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [COUNT_W-1:0] count_r;
  logic               do_push, do_pop;

  assign full    = count_r == COUNT_W'(frdb_pkg::QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(frdb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(frdb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_r + COUNT_W'(do_push) - COUNT_W'(do_pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
                   count_r <= COUNT_W'(frdb_pkg::QUEUE_DEPTH))
    else $error("frame queue count overrun");
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("frame request pushed into a full queue");

endmodule

[rtl/frdb_level.sv]
module frdb_level #(
  parameter int CNT_W = 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  logic [frdb_pkg::SUM_W-1:0]    q_sum,
  input  logic [CNT_W-1:0]              q_cnt,
  input  logic [frdb_pkg::DB_W-1:0]     floor_db,
  input  logic [frdb_pkg::DB_W-1:0]     ceiling_db,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [frdb_pkg::DB_W-1:0]     out_level_db
);

  // count times threshold stays below 2^(CNT_W+68) up to one decade past the top
  localparam int SCW    = CNT_W + 68;
  localparam int PROD_W = CNT_W + frdb_pkg::COEF_W;

  frdb_pkg::lvl_state_t state_r, state_nxt;

  logic [frdb_pkg::SUM_W-1:0]    sum_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [SCW-1:0]                scaled_r [frdb_pkg::NUM_FRAC];
  logic [frdb_pkg::FRAC_IDX_W-1:0] r_r, r_nxt;
  logic [frdb_pkg::DB_W-1:0]     d_r, d_nxt;
  logic [frdb_pkg::DB_W-1:0]     lvl_r, lvl_nxt;
  logic                          out_valid_r;
  logic [frdb_pkg::DB_W-1:0]     out_level_r;

  logic [PROD_W-1:0]             prod;
  logic [SCW-1:0]                left, cur, cur_x10;
  logic                          reach;
  logic                          out_free;
  logic                          deliver;

  function automatic logic [frdb_pkg::DB_W-1:0] clamp(
    input logic [frdb_pkg::DB_W-1:0] raw,
    input logic [frdb_pkg::DB_W-1:0] lo,
    input logic [frdb_pkg::DB_W-1:0] hi
  );
    logic [frdb_pkg::DB_W-1:0] v;
    if (raw < lo) v = lo;
    else if (raw > hi) v = hi;
    else v = raw;
    return v;
  endfunction

  assign prod    = cnt_r * frdb_pkg::load_coef(r_r);
  assign left    = SCW'({sum_r, {frdb_pkg::FRAC_SH{1'b0}}});
  assign cur     = scaled_r[r_r];
  assign cur_x10 = (cur << 3) + (cur << 1);
  assign reach   = left >= cur;
  assign out_free = !out_valid_r || out_pop;
  assign deliver = (state_r == frdb_pkg::LV_DONE) && out_free;
  assign q_pop   = (state_r == frdb_pkg::LV_IDLE) && !q_empty;

  always_comb begin
    state_nxt = state_r;
    r_nxt     = r_r;
    d_nxt     = d_r;
    lvl_nxt   = lvl_r;
    unique case (state_r)
      frdb_pkg::LV_IDLE: begin
        if (!q_empty) begin
          r_nxt = '0;
          if (q_sum == '0) begin
            // silent frame reports the floor with no ceiling clamp
            lvl_nxt   = floor_db;
            state_nxt = frdb_pkg::LV_DONE;
          end else begin
            state_nxt = frdb_pkg::LV_LOAD;
          end
        end
      end
      frdb_pkg::LV_LOAD: begin
        if (r_r == frdb_pkg::LAST_FRAC) begin
          r_nxt     = frdb_pkg::FRAC_IDX_W'(1);
          d_nxt     = frdb_pkg::DB_W'(1);
          state_nxt = frdb_pkg::LV_SEARCH;
        end else begin
          r_nxt = r_r + frdb_pkg::FRAC_IDX_W'(1);
        end
      end
      frdb_pkg::LV_SEARCH: begin
        if (!reach) begin
          lvl_nxt   = clamp(d_r - frdb_pkg::DB_W'(1), floor_db, ceiling_db);
          state_nxt = frdb_pkg::LV_DONE;
        end else if (d_r == frdb_pkg::TOP_DB) begin
          lvl_nxt   = clamp(frdb_pkg::TOP_DB, floor_db, ceiling_db);
          state_nxt = frdb_pkg::LV_DONE;
        end else begin
          d_nxt = d_r + frdb_pkg::DB_W'(1);
          r_nxt = (r_r == frdb_pkg::LAST_FRAC) ? '0 : r_r + frdb_pkg::FRAC_IDX_W'(1);
        end
      end
      frdb_pkg::LV_DONE: begin
        if (out_free) begin
          state_nxt = frdb_pkg::LV_IDLE;
        end
      end
      default: state_nxt = frdb_pkg::LV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= frdb_pkg::LV_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (deliver) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    r_r   <= r_nxt;
    d_r   <= d_nxt;
    lvl_r <= lvl_nxt;
    if (q_pop) begin
      sum_r <= q_sum;
      cnt_r <= q_cnt;
    end
    if (deliver) begin
      out_level_r <= lvl_r;
    end
    // load count times coefficient, then advance each entry one decade once it is passed
    if (state_r == frdb_pkg::LV_LOAD) begin
      scaled_r[r_r] <= SCW'(prod);
    end else if (state_r == frdb_pkg::LV_SEARCH && reach) begin
      scaled_r[r_r] <= cur_x10;
    end
  end

  assign out_empty    = !out_valid_r;
  assign out_level_db = out_level_r;

  assert property (@(posedge clk) disable iff (!rst_n)
                   state_r == frdb_pkg::LV_SEARCH |-> d_r >= frdb_pkg::DB_W'(1)
                   && d_r <= frdb_pkg::TOP_DB && r_r <= frdb_pkg::LAST_FRAC)
    else $error("level search step out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid_r && !out_pop |=> out_valid_r && $stable(out_level_r))
    else $error("pending level changed before it was taken");

endmodule

[rtl/frame_rms_level_db_core.sv]
// Frame power meter: signed 16-bit samples go in one per cycle; the sample
// flagged last closes the frame and yields one level, floor(10*log10(mean
// square)) in whole dB, clamped to [floor_db, ceiling_db]; a silent frame
// reports floor_db. Samples are accepted every cycle while in_full is low.
// Closed frames wait in a two-entry queue for the level unit, which walks
// the dB thresholds one step a cycle: it fetches the frame, loads the
// count-scaled coefficients, compares up to a level L (at most 120), then
// hands the result to the output register once that is free; a silent
// frame goes from fetch straight to handover. in_full rises only when
// frames end faster than the level unit drains them and the queue is full.
module frame_rms_level_db_core #(
  parameter int MAX_FRAME = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic signed [frdb_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                 in_last_sample,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic [frdb_pkg::DB_W-1:0]            out_level_db,
  input  logic                                 cfg_wr_en,
  input  logic [0:0]                           cfg_index,
  input  logic [frdb_pkg::DB_W-1:0]            cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_FRAME + 1);
  localparam int QW    = frdb_pkg::SUM_W + CNT_W;

  logic [frdb_pkg::DB_W-1:0] floor_r, ceil_r;
  logic                      take;
  logic                      acc_push;
  logic [frdb_pkg::SUM_W-1:0] acc_sum, q_sum;
  logic [CNT_W-1:0]           acc_cnt, q_cnt;
  logic [QW-1:0]              q_rdata;
  logic                       q_full, q_empty, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= frdb_pkg::FLOOR_RESET;
      ceil_r  <= frdb_pkg::CEIL_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        frdb_pkg::REG_FLOOR: floor_r <= cfg_wdata;
        frdb_pkg::REG_CEIL:  ceil_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_full = q_full;
  assign take    = in_push && !q_full;

  frdb_acc #(
    .MAX_FRAME(MAX_FRAME),
    .CNT_W    (CNT_W)
  ) u_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .sample     (in_sample),
    .last_sample(in_last_sample),
    .q_push     (acc_push),
    .q_sum      (acc_sum),
    .q_cnt      (acc_cnt)
  );

  frdb_queue #(
    .DW(QW)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (acc_push),
    .wdata({acc_sum, acc_cnt}),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  assign q_sum = q_rdata[QW-1:CNT_W];
  assign q_cnt = q_rdata[CNT_W-1:0];

  frdb_level #(
    .CNT_W(CNT_W)
  ) u_level (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_sum       (q_sum),
    .q_cnt       (q_cnt),
    .floor_db    (floor_r),
    .ceiling_db  (ceil_r),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_level_db(out_level_db)
  );

endmodule
